FILE: rtl/fjb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame jitter buffer package
// Shared widths, codes, payload types and state encoding for the frame
// jitter buffer and its checker.
// ============================================================================
package fjb_pkg;

    // Default number of descriptor slots in the queue memory.
    localparam int DEPTH_DEFAULT = 16;

    // Field widths.
    localparam int OP_W       = 2;
    localparam int HANDLE_W   = 32;
    localparam int PTS_W      = 32;
    localparam int TIME_W     = 48;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int COUNT_W    = 32;
    localparam int AVG_W      = 32;
    localparam int JSUM_W     = 64;
    localparam int JCNT_W     = 32;

    // Configuration port.
    localparam int LAT_MS_W   = 16;
    localparam int MAXF_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LATENCY_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES = 1'd1;

    // Latency is kept in microseconds; 65535 ms times 1000 fits in 26 bits.
    localparam int US_PER_MS  = 1000;
    localparam int LAT_US_W   = 26;
    localparam int LATENCY_MS_RESET = 100;
    localparam logic [LAT_US_W-1:0] LAT_US_RESET = LAT_US_W'(LATENCY_MS_RESET * US_PER_MS);
    localparam logic [MAXF_W-1:0]   MAX_FRAMES_RESET = 5'd16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_HELD  = 2'd2;

    // Average jitter divider: two quotient bits per cycle.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STEPS  = JSUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Divide by three for a 5-bit value: floor(x * 11 / 32) is exact up to 31.
    localparam int THIRD_MUL    = 11;
    localparam int THIRD_SHIFT  = 5;
    localparam int THIRD_PROD_W = MAXF_W + THIRD_SHIFT;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [HANDLE_W-1:0] frame_handle;
        logic [PTS_W-1:0]    pts;
        logic                key_frame;
        logic [TIME_W-1:0]   recv_time_us;
        logic [TIME_W-1:0]   now_us;
    } fjb_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] frame_handle_out;
        logic                key_frame_out;
        logic                dropped_oldest;
        logic [OCC_W-1:0]    occupancy;
        logic [COUNT_W-1:0]  dropped_total;
        logic [COUNT_W-1:0]  pushed_total;
        logic [AVG_W-1:0]    avg_jitter;
    } fjb_rsp_t;

    // One queue slot as stored in memory.
    typedef struct packed {
        logic [HANDLE_W-1:0] frame_handle;
        logic                key_frame;
        logic [TIME_W-1:0]   recv_time_us;
    } fjb_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } fjb_state_t;

    function automatic logic [MAXF_W-1:0] third_of(input logic [MAXF_W-1:0] x);
        logic [THIRD_PROD_W-1:0] prod;
        prod = THIRD_PROD_W'(x) * THIRD_PROD_W'(THIRD_MUL);
        return prod[THIRD_SHIFT +: MAXF_W];
    endfunction

endpackage

FILE: rtl/fjb_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ============================================================================
module fjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fjb_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// Average jitter divider
// Restoring divider, two quotient bits per cycle; returns the low bits of a
// 64-bit sum divided by a 32-bit count.
// ============================================================================
module fjb_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fjb_pkg::JSUM_W-1:0] dividend,
    input  logic [fjb_pkg::JCNT_W-1:0] divisor,
    output logic                       done,
    output logic [fjb_pkg::AVG_W-1:0]  quotient
);

    import fjb_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [JCNT_W-1:0]    rem_reg, rem_next;
    logic [JSUM_W-1:0]    dvd_reg, dvd_next;
    logic [AVG_W-1:0]     quo_reg, quo_next;
    logic [JCNT_W-1:0]    dsr_reg, dsr_next;

    logic [JCNT_W:0]      trial;
    logic [JCNT_W-1:0]    rem_step;
    logic [JSUM_W-1:0]    dvd_step;
    logic [AVG_W-1:0]     quo_step;

    // Two restoring steps; for a nonzero divisor the remainder always stays below it.
    always_comb
    begin
        rem_step = rem_reg;
        dvd_step = dvd_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_step, dvd_step[JSUM_W-1]};
            dvd_step = {dvd_step[JSUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial    = trial - {1'b0, dsr_reg};
                quo_step = {quo_step[AVG_W-2:0], 1'b1};
            end
            else
            begin
                quo_step = {quo_step[AVG_W-2:0], 1'b0};
            end
            rem_step = trial[JCNT_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = rem_step;
            dvd_next  = dvd_step;
            quo_next  = quo_step;
            step_next = step_reg + DIV_CNT_W'(1);
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/frame_jitter_buffer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame jitter buffer
// Bounded queue of frame descriptors with drop-oldest overflow, a release
// rule on pop, and running drop, push and PTS jitter statistics.
//
// Each request item is a push, a pop or a clear, and each one returns exactly
// one response item that carries the current statistics. The descriptors live
// in one synchronous RAM of DEPTH slots addressed as a ring from a head
// pointer. A push into a full queue (full meaning occupancy at or above the
// configured max_frames, clamped to 1..DEPTH) discards the oldest frame first.
// A pop releases the head if it is a key frame, if it has waited at least
// latency_ms milliseconds against now_us, or if occupancy is at least a third
// of the capacity; otherwise the head is reported as held and stays queued.
// The block handles one request item at a time. A clear, a push that adds no
// jitter sample, or a pop of an empty queue goes from execution straight to
// the response; a pop of a non-empty queue first passes through a read state
// for the head slot. A push that adds a jitter sample waits in a divide state
// while the average jitter is recomputed by a divider that produces two
// quotient bits per cycle over the 64-bit sum. A finished response item sits
// in an output register, so the next request item is taken while it waits.
// Configuration writes are to be made only while no request is in flight.
// ============================================================================
module frame_jitter_buffer_top #(
    parameter int DEPTH = fjb_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  fjb_pkg::fjb_req_t              req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output fjb_pkg::fjb_rsp_t              rsp,
    input  logic                           cfg_we,
    input  logic [fjb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fjb_pkg::CFG_DATA_W-1:0] cfg_data
);

    import fjb_pkg::*;

    // Address and fill count widths follow from DEPTH; the comparison width is the wider of fill count and max_frames.
    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (CNT_W > MAXF_W) ? CNT_W : MAXF_W;
    localparam int ENTRY_W = $bits(fjb_entry_t);

    // Sequencer.
    fjb_state_t state_reg, state_next;
    logic       mem_we;
    logic       div_start;
    logic       rsp_load;
    logic       rsp_free;

    // Configuration.
    logic [LAT_US_W-1:0] lat_us_reg, lat_us_next;
    logic [MAXF_W-1:0]   max_frames_reg, max_frames_next;

    // Queue and statistics state.
    fjb_req_t           item_reg, item_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [PTS_W-1:0]   last_pts_reg, last_pts_next;
    logic [JSUM_W-1:0]  jsum_reg, jsum_next;
    logic [JCNT_W-1:0]  jcnt_reg, jcnt_next;
    logic [COUNT_W-1:0] dropped_cnt_reg, dropped_cnt_next;
    logic [COUNT_W-1:0] pushed_cnt_reg, pushed_cnt_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;

    // Per-item result fields gathered before the response is built.
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                res_key_reg, res_key_next;
    logic                res_drop_reg, res_drop_next;

    // Response register.
    fjb_rsp_t rsp_reg, rsp_next;
    logic     rsp_valid_reg, rsp_valid_next;

    // Datapath helpers.
    logic [CNT_W-1:0]  cap;
    logic [MAXF_W-1:0] third;
    logic              is_push;
    logic              is_pop;
    logic              is_clear;
    logic              full;
    logic              third_ok;
    logic [AW-1:0]     head_inc;
    logic [SUM_W-1:0]  slot_sum;
    logic [AW-1:0]     slot;
    logic [TIME_W-1:0] recv_eff;
    logic              jit_hit;
    fjb_entry_t        wr_entry;
    fjb_entry_t        rd_entry;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [TIME_W-1:0] elapsed;
    logic              due;

    logic              div_done;
    logic [AVG_W-1:0]  div_quotient;

    // ------------------------------------------------------------------
    // Descriptor memory. The read port always looks at the head slot; a pop
    // uses the data in the cycle after it enters execution.
    // ------------------------------------------------------------------
    fjb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_fjb_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot),
        .wdata (wr_entry),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    fjb_divider u_fjb_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (jsum_next),
        .divisor  (jcnt_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Capacity in use: a programmed zero acts as one, and anything above the
    // memory depth acts as the depth. The release threshold is a third of it.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (max_frames_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (int'(max_frames_reg) > DEPTH)
        begin
            cap = CNT_W'(DEPTH);
        end
        else
        begin
            cap = CNT_W'(max_frames_reg);
        end
    end

    assign third    = third_of(MAXF_W'(cap));
    assign full     = CMP_W'(fill_reg) >= CMP_W'(cap);
    assign third_ok = CMP_W'(fill_reg) >= CMP_W'(third);

    assign is_push  = item_reg.operation == OP_PUSH;
    assign is_pop   = item_reg.operation == OP_POP;
    assign is_clear = item_reg.operation == OP_CLEAR;

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // The tail slot is head plus fill, whether or not the oldest frame is
    // dropped: dropping advances the head by one and leaves the fill as it was.
    assign slot_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign slot     = (slot_sum >= SUM_W'(DEPTH)) ? AW'(slot_sum - SUM_W'(DEPTH))
                                                  : AW'(slot_sum);

    // A receive time of zero means the frame is stamped with the current time.
    assign recv_eff = (item_reg.recv_time_us == '0) ? item_reg.now_us
                                                    : item_reg.recv_time_us;

    // Only forward PTS steps count, and only once a previous PTS is known.
    assign jit_hit = (last_pts_reg != '0) && (item_reg.pts > last_pts_reg);

    always_comb
    begin
        wr_entry.frame_handle = item_reg.frame_handle;
        wr_entry.key_frame    = item_reg.key_frame;
        wr_entry.recv_time_us = recv_eff;
    end

    // Release check for the head slot. A clock that reads behind the receive
    // time counts as no time elapsed.
    assign rd_entry = fjb_entry_t'(mem_rdata);
    assign elapsed  = (item_reg.now_us >= rd_entry.recv_time_us)
                    ? item_reg.now_us - rd_entry.recv_time_us : '0;
    assign due      = rd_entry.key_frame || (elapsed >= TIME_W'(lat_us_reg)) || third_ok;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_push && jit_hit)
                begin
                    state_next = ST_DIV;
                end
                else if (is_pop && (fill_reg != '0))
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        req_stall = 1'b1;
        mem_we    = 1'b0;
        div_start = 1'b0;
        rsp_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_EXEC:
            begin
                mem_we    = is_push;
                div_start = is_push && jit_hit;
            end
            ST_EMIT:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration writes. The latency is converted to microseconds here,
    // so the release check only needs a compare.
    // ------------------------------------------------------------------
    always_comb
    begin
        lat_us_next     = lat_us_reg;
        max_frames_next = max_frames_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LATENCY_MS:
                begin
                    lat_us_next = LAT_US_W'(32'(cfg_data[LAT_MS_W-1:0]) * 32'(US_PER_MS));
                end
                REG_MAX_FRAMES:
                begin
                    max_frames_next = cfg_data[MAXF_W-1:0];
                end
                default:
                begin
                    lat_us_next = lat_us_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Queue and statistics update.
    // ------------------------------------------------------------------
    always_comb
    begin
        item_next        = item_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        last_pts_next    = last_pts_reg;
        jsum_next        = jsum_reg;
        jcnt_next        = jcnt_reg;
        dropped_cnt_next = dropped_cnt_reg;
        pushed_cnt_next  = pushed_cnt_reg;
        avg_next         = avg_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        res_key_next     = res_key_reg;
        res_drop_next    = res_drop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                end
            end
            ST_EXEC:
            begin
                res_status_next = STAT_DONE;
                res_handle_next = '0;
                res_key_next    = 1'b0;
                res_drop_next   = 1'b0;
                if (is_push)
                begin
                    if (full)
                    begin
                        // Oldest frame goes; the count stays where it was.
                        head_next        = head_inc;
                        dropped_cnt_next = dropped_cnt_reg + COUNT_W'(1);
                        res_drop_next    = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    pushed_cnt_next = pushed_cnt_reg + COUNT_W'(1);
                    if (jit_hit)
                    begin
                        jsum_next = jsum_reg + JSUM_W'(item_reg.pts - last_pts_reg);
                        jcnt_next = jcnt_reg + JCNT_W'(1);
                    end
                    last_pts_next = item_reg.pts;
                end
                else if (is_pop)
                begin
                    if (fill_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                end
                else if (is_clear)
                begin
                    fill_next     = '0;
                    head_next     = '0;
                    last_pts_next = '0;
                end
            end
            ST_READ:
            begin
                res_handle_next = rd_entry.frame_handle;
                res_key_next    = rd_entry.key_frame;
                if (due)
                begin
                    head_next = head_inc;
                    fill_next = fill_reg - CNT_W'(1);
                end
                else
                begin
                    res_status_next = STAT_HELD;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    // A wrapped sample count reads as no samples.
                    avg_next = (jcnt_reg == '0) ? '0 : div_quotient;
                end
            end
            default:
            begin
                item_next = item_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Response register: loaded when the previous item has been taken.
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (rsp_load)
        begin
            rsp_next.status           = res_status_reg;
            rsp_next.frame_handle_out = res_handle_reg;
            rsp_next.key_frame_out    = res_key_reg;
            rsp_next.dropped_oldest   = res_drop_reg;
            rsp_next.occupancy        = OCC_W'(fill_reg);
            rsp_next.dropped_total    = dropped_cnt_reg;
            rsp_next.pushed_total     = pushed_cnt_reg;
            rsp_next.avg_jitter       = avg_reg;
            rsp_valid_next            = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lat_us_reg      <= LAT_US_RESET;
            max_frames_reg  <= MAX_FRAMES_RESET;
            head_reg        <= '0;
            fill_reg        <= '0;
            last_pts_reg    <= '0;
            jsum_reg        <= '0;
            jcnt_reg        <= '0;
            dropped_cnt_reg <= '0;
            pushed_cnt_reg  <= '0;
            avg_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lat_us_reg      <= lat_us_next;
            max_frames_reg  <= max_frames_next;
            head_reg        <= head_next;
            fill_reg        <= fill_next;
            last_pts_reg    <= last_pts_next;
            jsum_reg        <= jsum_next;
            jcnt_reg        <= jcnt_next;
            dropped_cnt_reg <= dropped_cnt_next;
            pushed_cnt_reg  <= pushed_cnt_next;
            avg_reg         <= avg_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_key_reg    <= res_key_next;
        res_drop_reg   <= res_drop_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/fjb_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame jitter buffer checker
// Port-level assertions on the request and response channels, bound to the
// top level.
// ============================================================================
module fjb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input fjb_pkg::fjb_rsp_t rsp
);

    import fjb_pkg::*;

    // A waiting response item holds still until it is taken.
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp))
    ) else $error("response item changed while stalled");

    // Only one request item is in work at a time.
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall
    ) else $error("second request item taken while one is in work");

    // An empty pop reports an empty queue and no frame.
    a_empty_pop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STAT_EMPTY))
            |-> ((rsp.occupancy == '0) && (rsp.frame_handle_out == '0)
                 && !rsp.key_frame_out && !rsp.dropped_oldest)
    ) else $error("empty status with frame data or nonzero occupancy");

    // A push that dropped the oldest frame completes and leaves frames queued.
    a_drop_push: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.dropped_oldest)
            |-> ((rsp.status == STAT_DONE) && (rsp.occupancy != '0)
                 && (rsp.frame_handle_out == '0))
    ) else $error("drop reported on a result that is not a completed push");

endmodule

bind frame_jitter_buffer_top fjb_checker u_fjb_checker (.*);
